FILE: rtl/core/bba_pkg.sv
// Package with constants, types and status codes of the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;
  localparam int MaxOrderDefault = 10;
  localparam int MaxBlocksDefault = 512;
  localparam int OrderW = 4;
  localparam int AmountW = 11;
  localparam int AddrW = 10;
  localparam int StatusW = 3;

  localparam logic [StatusW-1:0] ST_OK = 3'd0;
  localparam logic [StatusW-1:0] ST_ZERO = 3'd1;
  localparam logic [StatusW-1:0] ST_NOSPACE = 3'd2;
  localparam logic [StatusW-1:0] ST_RANGE = 3'd3;
  localparam logic [StatusW-1:0] ST_NOBLOCK = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXACT_RD,
    S_EXACT_CHK,
    S_SPLIT_RD,
    S_SPLIT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FILL,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_PULL_RD,
    S_PULL_WR,
    S_DONE
  } bba_state_t;
endpackage

FILE: rtl/core/bba_if.sv
// Valid/ready channel interface carrying one transaction payload.
`timescale 1ns / 1ps
interface bba_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/bba_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/buddy_block_allocator_unit.sv
// Buddy allocator: a sequencer that walks the block list in RAM, one entry a step.
// One transaction is taken at a time, and each list entry visited takes a RAM read, then
// a check. An allocate first scans the whole list for an exact fit and then scans for a
// block to split. A split moves the tail of the list up, with a read and a write per
// entry, and then writes the new entries. A free scans to its block. After every merge
// it pulls the tail down, with a read and a write per entry, and rescans from the start;
// a free can make up to MaxOrder-1 merges. The list RAM is single-port. The result is
// held in an output register, so a new transaction can be accepted while it waits, but
// the next result waits until it has been taken. List entry 0 is written during reset
// and by a configuration write in the idle state, which takes effect on the next cycle.
`timescale 1ns / 1ps
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MaxOrder = MaxOrderDefault,
  parameter int MaxBlocks = MaxBlocksDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [OrderW-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_action,
  input  logic [AmountW-1:0] in_amount,
  input  logic [AddrW-1:0] in_address,
  output logic out_valid,
  input  logic out_ready,
  output logic [StatusW-1:0] out_status,
  output logic [AddrW-1:0] out_start_address
);
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);
  localparam int SumW = MaxOrder + 2;
  localparam int EntW = OrderW + 1;
  localparam logic [OrderW-1:0] ResetOrder = OrderW'(MaxOrder < 10 ? MaxOrder : 10);

  bba_state_t state_r, state_nxt;
  logic [OrderW-1:0] mem_order_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] i_r, i_nxt;
  logic [CntW-1:0] j_r, j_nxt;
  logic [SumW-1:0] start_r, start_nxt;
  logic [OrderW-1:0] k_r, k_nxt;
  logic [OrderW-1:0] s_r, s_nxt;
  logic [OrderW-1:0] prev_o_r, prev_o_nxt;
  logic prev_u_r, prev_u_nxt;
  logic [AddrW-1:0] addr_r, addr_nxt;
  logic [StatusW-1:0] st_r, st_nxt;
  logic [AddrW-1:0] res_r, res_nxt;
  logic [StatusW-1:0] out_st_r, out_st_nxt;
  logic [AddrW-1:0] out_addr_r, out_addr_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [CntW-1:0] ram_idx;
  logic ram_we;
  logic [EntW-1:0] ram_wd, ram_rd;
  logic [OrderW-1:0] rd_o;
  logic rd_u;
  logic [OrderW-1:0] cfg_clamped;
  logic [OrderW-1:0] req_k;
  logic [SumW-1:0] blk_sz;

  assign rd_o = ram_rd[OrderW-1:0];
  assign rd_u = ram_rd[OrderW];
  assign blk_sz = SumW'(1) << rd_o;

  bba_ram #(.Width(EntW), .Depth(MaxBlocks)) u_list (
    .clk(clk), .we(ram_we), .addr(ram_idx[IdxW-1:0]), .wdata(ram_wd), .rdata(ram_rd)
  );

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = OrderW'(1);
    end else if (32'(cfg_wdata) > MaxOrder) begin
      cfg_clamped = OrderW'(MaxOrder);
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  always_comb begin
    req_k = OrderW'(1);
    for (int b = 2; b < 12; b++) begin
      if (in_amount > AmountW'((1 << (b - 1)))) begin
        req_k = OrderW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mem_order_r <= ResetOrder;
      cnt_r <= CntW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mem_order_r <= cfg_clamped;
      end
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    start_r <= start_nxt;
    k_r <= k_nxt;
    s_r <= s_nxt;
    prev_o_r <= prev_o_nxt;
    prev_u_r <= prev_u_nxt;
    addr_r <= addr_nxt;
    st_r <= st_nxt;
    res_r <= res_nxt;
    out_st_r <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_st_r;
  assign out_start_address = out_addr_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;
    j_nxt = j_r;
    start_nxt = start_r;
    k_nxt = k_r;
    s_nxt = s_r;
    prev_o_nxt = prev_o_r;
    prev_u_nxt = prev_u_r;
    addr_nxt = addr_r;
    st_nxt = st_r;
    res_nxt = res_r;
    out_st_nxt = out_st_r;
    out_addr_nxt = out_addr_r;
    out_valid_nxt = out_valid_r;
    ram_idx = i_r;
    ram_we = 1'b0;
    ram_wd = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          ram_idx = '0;
          ram_we = 1'b1;
          ram_wd = {1'b0, cfg_clamped};
          cnt_nxt = CntW'(1);
        end else if (in_valid && in_ready) begin
          i_nxt = '0;
          start_nxt = '0;
          res_nxt = '0;
          k_nxt = req_k;
          addr_nxt = in_address;
          if (in_action == ACT_ALLOC) begin
            if (in_amount == '0) begin
              st_nxt = ST_ZERO;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_EXACT_RD;
            end
          end else if (SumW'(in_address) >= (SumW'(1) << mem_order_r)) begin
            st_nxt = ST_RANGE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FREE_RD;
          end
        end
      end
      S_EXACT_RD: begin
        if (i_r >= cnt_r) begin
          i_nxt = '0;
          start_nxt = '0;
          state_nxt = S_SPLIT_RD;
        end else begin
          state_nxt = S_EXACT_CHK;
        end
      end
      S_EXACT_CHK: begin
        if (!rd_u && rd_o == k_r) begin
          ram_we = 1'b1;
          ram_wd = {1'b1, rd_o};
          st_nxt = ST_OK;
          res_nxt = AddrW'(start_r);
          state_nxt = S_DONE;
        end else begin
          start_nxt = start_r + blk_sz;
          i_nxt = i_r + CntW'(1);
          state_nxt = S_EXACT_RD;
        end
      end
      S_SPLIT_RD: begin
        if (i_r >= cnt_r) begin
          st_nxt = ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SPLIT_CHK;
        end
      end
      S_SPLIT_CHK: begin
        if (!rd_u && rd_o > k_r &&
            (32'(cnt_r) + 32'(rd_o - k_r)) <= MaxBlocks) begin
          s_nxt = rd_o;
          res_nxt = AddrW'(start_r);
          j_nxt = cnt_r - CntW'(1);
          state_nxt = S_SHIFT_RD;
        end else begin
          start_nxt = start_r + blk_sz;
          i_nxt = i_r + CntW'(1);
          state_nxt = S_SPLIT_RD;
        end
      end
      S_SHIFT_RD: begin
        ram_idx = j_r;
        if (j_r <= i_r) begin
          j_nxt = '0;
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ram_idx = j_r + CntW'(s_r - k_r);
        ram_we = 1'b1;
        ram_wd = ram_rd;
        j_nxt = j_r - CntW'(1);
        state_nxt = S_SHIFT_RD;
      end
      S_FILL: begin
        ram_idx = i_r + j_r;
        ram_we = 1'b1;
        if (j_r == '0) begin
          ram_wd = {1'b1, k_r};
        end else begin
          ram_wd = {1'b0, OrderW'(k_r + OrderW'(j_r) - OrderW'(1))};
        end
        if (j_r == CntW'(s_r - k_r)) begin
          cnt_nxt = cnt_r + CntW'(s_r - k_r);
          st_nxt = ST_OK;
          state_nxt = S_DONE;
        end else begin
          j_nxt = j_r + CntW'(1);
        end
      end
      S_FREE_RD: begin
        if (i_r >= cnt_r) begin
          st_nxt = ST_NOBLOCK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (start_r == SumW'(addr_r)) begin
          if (!rd_u) begin
            st_nxt = ST_NOBLOCK;
            state_nxt = S_DONE;
          end else begin
            ram_we = 1'b1;
            ram_wd = {1'b0, rd_o};
            st_nxt = ST_OK;
            i_nxt = '0;
            start_nxt = '0;
            state_nxt = S_MERGE_RD;
          end
        end else begin
          start_nxt = start_r + blk_sz;
          i_nxt = i_r + CntW'(1);
          state_nxt = S_FREE_RD;
        end
      end
      S_MERGE_RD: begin
        if (i_r >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MERGE_CHK;
        end
      end
      S_MERGE_CHK: begin
        if (i_r != '0 && !prev_u_r && !rd_u && rd_o == prev_o_r &&
            start_r[prev_o_r] == 1'b0) begin
          ram_idx = i_r - CntW'(1);
          ram_we = 1'b1;
          ram_wd = {1'b0, OrderW'(prev_o_r + OrderW'(1))};
          j_nxt = i_r + CntW'(1);
          state_nxt = S_PULL_RD;
        end else begin
          prev_o_nxt = rd_o;
          prev_u_nxt = rd_u;
          if (i_r != '0) begin
            start_nxt = start_r + (SumW'(1) << prev_o_r);
          end
          i_nxt = i_r + CntW'(1);
          state_nxt = S_MERGE_RD;
        end
      end
      S_PULL_RD: begin
        ram_idx = j_r;
        if (j_r >= cnt_r) begin
          cnt_nxt = cnt_r - CntW'(1);
          i_nxt = '0;
          start_nxt = '0;
          state_nxt = S_MERGE_RD;
        end else begin
          state_nxt = S_PULL_WR;
        end
      end
      S_PULL_WR: begin
        ram_idx = j_r - CntW'(1);
        ram_we = 1'b1;
        ram_wd = ram_rd;
        j_nxt = j_r + CntW'(1);
        state_nxt = S_PULL_RD;
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = st_r;
          out_addr_nxt = (st_r == ST_OK) ? res_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (!rst_n) begin
      ram_idx = '0;
      ram_we = 1'b1;
      ram_wd = {1'b0, ResetOrder};
    end
  end

`ifndef SYNTHESIS
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && 32'(cnt_r) <= MaxBlocks)
    else $error("block count out of range");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("ready while busy");
  a_ok_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_start_address == '0)
    else $error("address on failed transaction");
  a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_order_r != '0 && 32'(mem_order_r) <= MaxOrder)
    else $error("memory order out of range");
`endif
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the buddy block allocator unit.
`timescale 1ns / 1ps
module testbench;
  import bba_pkg::*;

  typedef struct packed {
    logic action;
    logic [AmountW-1:0] amount;
    logic [AddrW-1:0] address;
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0] start_address;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [OrderW-1:0] cfg_wdata;

  bba_if #(.payload_t(request_t)) req_ch ();
  bba_if #(.payload_t(outcome_t)) res_ch ();

  buddy_block_allocator_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(req_ch.valid),
    .in_ready(req_ch.ready),
    .in_action(req_ch.data.action),
    .in_amount(req_ch.data.amount),
    .in_address(req_ch.data.address),
    .out_valid(res_ch.valid),
    .out_ready(res_ch.ready),
    .out_status(res_ch.data.status),
    .out_start_address(res_ch.data.start_address)
  );

  int unsigned blk_order[MaxBlocksDefault];
  bit blk_used[MaxBlocksDefault];
  int unsigned blk_count;
  int unsigned mem_ord;
  outcome_t pending_outcomes[$];
  logic [AddrW-1:0] live_addrs[$];
  bit failed;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_list(input int unsigned order);
    mem_ord = order < 1 ? 1 : (order > MaxOrderDefault ? MaxOrderDefault : order);
    foreach (blk_order[i]) begin
      blk_order[i] = 0;
      blk_used[i] = 0;
    end
    blk_order[0] = mem_ord;
    blk_count = 1;
  endfunction

  function automatic void coalesce_free_buddies();
    int unsigned i;
    longint unsigned base;
    longint unsigned nxt;
    int unsigned o;
    i = 0;
    base = 0;
    while (i + 1 < blk_count) begin
      o = blk_order[i];
      nxt = base + (64'd1 << o);
      if (!blk_used[i] && !blk_used[i+1] && blk_order[i+1] == o &&
          (base >> (o + 1)) == (nxt >> (o + 1))) begin
        blk_order[i] = o + 1;
        for (int j = i + 1; j + 1 < blk_count; j++) begin
          blk_order[j] = blk_order[j+1];
          blk_used[j] = blk_used[j+1];
        end
        blk_count--;
        blk_order[blk_count] = 0;
        blk_used[blk_count] = 0;
        i = 0;
        base = 0;
      end else begin
        base = nxt;
        i++;
      end
    end
  endfunction

  function automatic outcome_t allocate_block(input int unsigned amount);
    outcome_t r;
    int unsigned k;
    int unsigned s;
    int unsigned n;
    longint unsigned base;
    r.status = ST_NOSPACE;
    r.start_address = '0;
    if (amount == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    k = 1;
    while (k < 12 && (1 << k) < amount) k++;
    base = 0;
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_used[i] && blk_order[i] == k) begin
        blk_used[i] = 1;
        r.status = ST_OK;
        r.start_address = base[AddrW-1:0];
        return r;
      end
      base += 64'd1 << blk_order[i];
    end
    base = 0;
    for (int i = 0; i < blk_count; i++) begin
      s = blk_order[i];
      if (!blk_used[i] && s > k && blk_count + (s - k) <= MaxBlocksDefault) begin
        n = s - k;
        for (int j = blk_count - 1; j > i; j--) begin
          blk_order[j+n] = blk_order[j];
          blk_used[j+n] = blk_used[j];
        end
        blk_order[i] = k;
        blk_used[i] = 1;
        for (int j = 0; j < n; j++) begin
          blk_order[i+1+j] = k + j;
          blk_used[i+1+j] = 0;
        end
        blk_count += n;
        r.status = ST_OK;
        r.start_address = base[AddrW-1:0];
        return r;
      end
      base += 64'd1 << s;
    end
    return r;
  endfunction

  function automatic outcome_t release_block(input int unsigned address);
    outcome_t r;
    longint unsigned base;
    r.start_address = '0;
    r.status = ST_NOBLOCK;
    if (address >= (1 << mem_ord)) begin
      r.status = ST_RANGE;
      return r;
    end
    base = 0;
    for (int i = 0; i < blk_count; i++) begin
      if (base == address) begin
        if (blk_used[i]) begin
          blk_used[i] = 0;
          coalesce_free_buddies();
          r.status = ST_OK;
        end
        return r;
      end
      base += 64'd1 << blk_order[i];
    end
    return r;
  endfunction

  function automatic void forget_live(input logic [AddrW-1:0] a);
    foreach (live_addrs[i]) begin
      if (live_addrs[i] == a) begin
        live_addrs.delete(i);
        return;
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(input request_t rq);
    int unsigned gap;
    outcome_t e;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= rq;
    do @(posedge clk); while (!req_ch.ready);
    if (rq.action == ACT_ALLOC) begin
      e = allocate_block(rq.amount);
      if (e.status == ST_OK) live_addrs.push_back(e.start_address);
    end else begin
      e = release_block(rq.address);
      if (e.status == ST_OK) forget_live(rq.address);
    end
    pending_outcomes.push_back(e);
  endtask

  task automatic alloc_req(input int unsigned amount);
    request_t rq;
    rq.action = ACT_ALLOC;
    rq.amount = AmountW'(amount);
    rq.address = AddrW'($urandom_range(0, 1023));
    send_request(rq);
  endtask

  task automatic free_req(input int unsigned address);
    request_t rq;
    rq.action = ACT_FREE;
    rq.amount = AmountW'($urandom_range(0, 2047));
    rq.address = AddrW'(address);
    send_request(rq);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_order(input logic [OrderW-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    clear_list(v);
    live_addrs.delete();
  endtask

  task automatic test_directed();
    alloc_req(0);
    alloc_req(1);
    alloc_req(2047);
    alloc_req(1024);
    free_req(1023);
    free_req(0);
    free_req(0);
    alloc_req(1024);
    free_req(0);
    alloc_req(3);
    alloc_req(5);
    alloc_req(2);
    free_req(8);
    free_req(6);
    free_req(0);
    free_req(4);
    write_order(4'd3);
    free_req(8);
    free_req(1023);
    alloc_req(16);
    alloc_req(8);
    alloc_req(1);
    free_req(0);
  endtask

  task automatic test_random(input logic [OrderW-1:0] order, input int unsigned count,
                             input bit tiny_blocks);
    int unsigned r;
    write_order(order);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 50 || (tiny_blocks && r < 85)) begin
        if (tiny_blocks) alloc_req($urandom_range(1, 2));
        else if ($urandom_range(0, 3) != 0) alloc_req($urandom_range(1, 8));
        else alloc_req($urandom_range(1, 1 << mem_ord));
      end else if (r < 93 && live_addrs.size() != 0) begin
        free_req(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end else if (r < 96) begin
        alloc_req($urandom_range(0, 1) ? 0 : $urandom_range(0, 2047));
      end else begin
        free_req($urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    out_ready_drive();
  end

  task automatic out_ready_drive();
    int unsigned hold;
    res_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        res_ch.ready <= ~res_ch.ready;
        hold = res_ch.ready ? pick_gap() : $urandom_range(0, 20);
      end
    end
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected transaction: status %0d start_address %0d",
               res_ch.data.status, res_ch.data.start_address);
        failed = 1'b1;
      end else begin
        e = pending_outcomes.pop_front();
        if (res_ch.data.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, res_ch.data.status);
          failed = 1'b1;
        end
        if (res_ch.data.start_address !== e.start_address) begin
          $error("start_address: expected %0d, actual %0d", e.start_address,
                 res_ch.data.start_address);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    failed = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    clear_list(MaxOrderDefault);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(4'd10, 390, 1'b1);
    test_random(4'd1, 30, 1'b0);
    test_random(4'd4, 40, 1'b0);
    test_random(4'd15, 40, 1'b0);
    test_random(4'd0, 20, 1'b0);
    test_random(4'd10, 40, 1'b0);
    wait_drained();
    repeat (200) @(posedge clk);
    if (!failed && pending_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
